### hdl/tht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tht_pkg
// shared constants, status codes and defaults of the token hash table
// ----------------------------------------------------------------------------
package tht_pkg;

    localparam int DEF_MAX_KEY_BYTES  = 16;
    localparam int DEF_TOKEN_CAPACITY = 4096;
    localparam int DEF_SLOT_BITS      = 13;

    localparam logic [31:0] HASH_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

    localparam int TOKEN_ID_W = 12;
    localparam int STATUS_W   = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

endpackage
`default_nettype wire

### hdl/token_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// token_hash_table
// maps byte-string keys to dense token ids with an fnv-1a linear probe table
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   action, key_byte, key_last
//  out      out_valid / out_ready status, token_id
//
//  one key byte per cycle while in_ready; the last byte queues a probe job, taken
//  in idle; each occupied slot passes slot wait, slot check and token check, the
//  empty slot ending a miss slot wait and slot check; an over-long key answers
//  when taken; after reset a pass clears all 2**SLOT_BITS slots, no transfer
//  meanwhile; a job starts only with the output register empty; a two-entry job
//  queue lets key bytes flow while the probe engine or output stalls
// ----------------------------------------------------------------------------
module token_hash_table
    import tht_pkg::*;
#(
    parameter int MAX_KEY_BYTES  = DEF_MAX_KEY_BYTES,
    parameter int TOKEN_CAPACITY = DEF_TOKEN_CAPACITY,
    parameter int SLOT_BITS      = DEF_SLOT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic [7:0]            key_byte,
    input  wire logic                  key_last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [TOKEN_ID_W-1:0]      token_id
);

    localparam int LW    = $clog2(MAX_KEY_BYTES + 1);
    localparam int JOB_W = 2 + LW + MAX_KEY_BYTES * 8 + SLOT_BITS;

    logic             enable;
    logic             q_full;
    logic             q_push;
    logic [JOB_W-1:0] q_in;
    logic             q_pop;
    logic             q_valid;
    logic [JOB_W-1:0] q_out;

    tht_front #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES),
        .SLOT_BITS    (SLOT_BITS),
        .JOB_W        (JOB_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .key_byte (key_byte),
        .key_last (key_last),
        .enable   (enable),
        .job_full (q_full),
        .job_push (q_push),
        .job_data (q_in)
    );

    tht_queue #(
        .W(JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    tht_back #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .TOKEN_CAPACITY(TOKEN_CAPACITY),
        .SLOT_BITS     (SLOT_BITS),
        .JOB_W         (JOB_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (q_valid),
        .job_data       (q_out),
        .job_pop        (q_pop),
        .ready_for_keys (enable),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .token_id       (token_id)
    );

endmodule
`default_nettype wire

### hdl/tht_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tht_queue
// two-entry job queue between the key front end and the probe engine
// ----------------------------------------------------------------------------
module tht_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      pop_data
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && not_empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push && !full) - 2'(pop && not_empty);
        end
    end

endmodule
`default_nettype wire

### hdl/tht_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tht_front
// takes key bytes, keeps the running hash and key copy, emits one job per key
// ----------------------------------------------------------------------------
module tht_front
    import tht_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES,
    parameter int SLOT_BITS     = DEF_SLOT_BITS,
    parameter int JOB_W         = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             action,
    input  wire logic [7:0]       key_byte,
    input  wire logic             key_last,
    input  wire logic             enable,
    input  wire logic             job_full,
    output logic                  job_push,
    output logic [JOB_W-1:0]      job_data
);

    localparam int KW = MAX_KEY_BYTES * 8;
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);

    logic [31:0]   hash_reg;
    logic [KW-1:0] key_reg;
    logic [LW-1:0] count_reg;
    logic          ovf_reg;

    logic [31:0]   hash_next;
    logic [KW-1:0] key_next;
    logic [LW-1:0] count_next;
    logic          ovf_next;
    logic          accept;

    assign in_ready = enable && !job_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hash_next  = (hash_reg ^ {24'd0, key_byte}) * HASH_PRIME;
        key_next   = key_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (count_reg < LW'(MAX_KEY_BYTES))
        begin
            for (int i = 0; i < MAX_KEY_BYTES; i++)
            begin
                if (count_reg == LW'(i))
                begin
                    key_next[i*8 +: 8] = key_byte;
                end
            end
            count_next = count_reg + LW'(1);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign job_push = accept && key_last;
    assign job_data = {action, ovf_next, count_next, key_next, hash_next[SLOT_BITS-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= HASH_BASIS;
            key_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (key_last)
            begin
                hash_reg  <= HASH_BASIS;
                key_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                hash_reg  <= hash_next;
                key_reg   <= key_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/tht_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tht_back
// probe engine: clears the slot table, probes linearly, inserts, answers
// ----------------------------------------------------------------------------
module tht_back
    import tht_pkg::*;
#(
    parameter int MAX_KEY_BYTES  = DEF_MAX_KEY_BYTES,
    parameter int TOKEN_CAPACITY = DEF_TOKEN_CAPACITY,
    parameter int SLOT_BITS      = DEF_SLOT_BITS,
    parameter int JOB_W          = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    input  wire logic [JOB_W-1:0]      job_data,
    output logic                       job_pop,
    output logic                       ready_for_keys,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [TOKEN_ID_W-1:0]      token_id
);

    localparam int KW         = MAX_KEY_BYTES * 8;
    localparam int LW         = $clog2(MAX_KEY_BYTES + 1);
    localparam int IDW        = $clog2(TOKEN_CAPACITY);
    localparam int CW         = IDW + 1;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int HALF       = SLOT_COUNT / 2;
    localparam int CMPW       = ((CW > SLOT_BITS) ? CW : SLOT_BITS) + 1;
    localparam int TW         = LW + KW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT_WAIT,
        S_SLOT_CHK,
        S_TOK_CHK
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOT_BITS-1:0]   probe_reg, probe_next;
    logic [JOB_W-1:0]       job_reg, job_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg, status_next;
    logic [TOKEN_ID_W-1:0]  id_reg, id_next;

    logic [IDW:0]           slot_mem [SLOT_COUNT];
    logic [TW-1:0]          tok_mem [TOKEN_CAPACITY];
    logic [IDW:0]           slot_q;
    logic [TW-1:0]          tok_q;

    logic                   slot_we;
    logic [SLOT_BITS-1:0]   slot_waddr;
    logic [IDW:0]           slot_wdata;
    logic                   tok_we;

    logic [KW-1:0]          j_key;
    logic [LW-1:0]          j_len;
    logic                   j_act;
    logic                   table_full;
    logic                   res_set;

    assign j_key  = job_reg[SLOT_BITS +: KW];
    assign j_len  = job_reg[SLOT_BITS+KW +: LW];
    assign j_act  = job_reg[JOB_W-1];

    assign table_full = (CMPW'(cnt_reg) >= CMPW'(TOKEN_CAPACITY))
                     || (CMPW'(cnt_reg) >= CMPW'(HALF));

    assign ready_for_keys = (state_reg != S_CLEAR);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign token_id       = id_reg;

    always_comb
    begin
        state_next     = state_reg;
        probe_next     = probe_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        id_next        = id_reg;
        job_pop        = 1'b0;
        slot_we        = 1'b0;
        slot_waddr     = probe_reg;
        slot_wdata     = {1'b1, cnt_reg[IDW-1:0]};
        tok_we         = 1'b0;
        res_set        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_wdata = '0;
                probe_next = probe_reg + SLOT_BITS'(1);
                if (probe_reg == SLOT_BITS'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_valid && !out_valid_reg)
                begin
                    job_pop    = 1'b1;
                    job_next   = job_data;
                    probe_next = job_data[SLOT_BITS-1:0];
                    if (job_data[SLOT_BITS+KW+LW])
                    begin
                        res_set     = 1'b1;
                        status_next = ST_TOO_LONG;
                        id_next     = '0;
                    end
                    else
                    begin
                        state_next = S_SLOT_WAIT;
                    end
                end
            end
            S_SLOT_WAIT:
            begin
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                if (!slot_q[IDW])
                begin
                    res_set    = 1'b1;
                    state_next = S_IDLE;
                    id_next    = '0;
                    if (!j_act)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (table_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        slot_we     = 1'b1;
                        tok_we      = 1'b1;
                        cnt_next    = cnt_reg + CW'(1);
                        status_next = ST_INSERTED;
                        id_next     = TOKEN_ID_W'(cnt_reg[IDW-1:0]);
                    end
                end
                else
                begin
                    state_next = S_TOK_CHK;
                end
            end
            S_TOK_CHK:
            begin
                if (tok_q == {j_len, j_key})
                begin
                    res_set     = 1'b1;
                    status_next = ST_FOUND;
                    id_next     = TOKEN_ID_W'(slot_q[IDW-1:0]);
                    state_next  = S_IDLE;
                end
                else
                begin
                    probe_next = probe_reg + SLOT_BITS'(1);
                    state_next = S_SLOT_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (res_set)
        begin
            out_valid_next = 1'b1;
        end
    end

    // slot table and token store
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[probe_reg];
        if (tok_we)
        begin
            tok_mem[cnt_reg[IDW-1:0]] <= {j_len, j_key};
        end
        tok_q <= tok_mem[slot_q[IDW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            probe_reg     <= '0;
            job_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_FOUND;
            id_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            probe_reg     <= probe_next;
            job_reg       <= job_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            id_reg        <= id_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(cnt_reg) <= CMPW'(HALF))
        else $error("token count beyond half the slots");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !job_pop)
        else $error("job taken during clearing pass");
    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_set |-> !out_valid_reg)
        else $error("result overwrites pending output");
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_set && status_next == ST_INSERTED) |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("insert did not advance token count");
`endif

endmodule
`default_nettype wire

### verif/token_hash_table_test.sv
// ----------------------------------------------------------------------------
// token_hash_table_test
// Self-checking bench for the token hash table. Keys are streamed one byte
// per transfer. A scoreboard keeps its own fnv-1a hash, slot table and token
// store, predicts each status and id, and compares them in order. The run has
// several idle and stall phases and a long output hold-off.
// ----------------------------------------------------------------------------
module token_hash_table_test;
    import tht_pkg::*;

    localparam int KEY_MAX   = DEF_MAX_KEY_BYTES;
    localparam int TOK_CAP   = DEF_TOKEN_CAPACITY;
    localparam int SLOTS     = 1 << DEF_SLOT_BITS;
    localparam int WATCH_LIM = 200000;
    localparam int POOL_N    = 40;

    typedef struct packed {
        status_t              st;
        logic [TOKEN_ID_W-1:0] id;
    } answer_t;

    class table_scoreboard;
        bit                    slot_used [SLOTS];
        int                    slot_tok  [SLOTS];
        logic [7:0]            tok_bytes [TOK_CAP][KEY_MAX];
        int                    tok_len   [TOK_CAP];
        int                    tok_count;
        logic [31:0]           hash;
        logic [7:0]            kbuf [KEY_MAX];
        int                    kcnt;
        bit                    kover;
        answer_t               answers [$];
        int                    errors;
        int                    checked;
        int                    seen [5];

        function new();
            foreach (slot_used[i]) slot_used[i] = 0;
            tok_count = 0;
            errors = 0;
            checked = 0;
            foreach (seen[i]) seen[i] = 0;
            clear_key();
        endfunction

        function void clear_key();
            hash = HASH_BASIS;
            foreach (kbuf[i]) kbuf[i] = 8'h00;
            kcnt = 0;
            kover = 0;
        endfunction

        function bit same_key(int t);
            if (tok_len[t] != kcnt) return 0;
            for (int i = 0; i < kcnt; i++)
                if (tok_bytes[t][i] != kbuf[i]) return 0;
            return 1;
        endfunction

        function void note_transfer(logic act, logic [7:0] b, logic last);
            answer_t a;
            int idx;
            int hit;
            int empty_at;
            hash = (hash ^ {24'h0, b}) * HASH_PRIME;
            if (kcnt < KEY_MAX)
            begin
                kbuf[kcnt] = b;
                kcnt++;
            end
            else
                kover = 1;
            if (!last) return;
            a.id = '0;
            if (kover)
                a.st = ST_TOO_LONG;
            else
            begin
                idx = int'(hash[DEF_SLOT_BITS-1:0]);
                hit = -1;
                empty_at = -1;
                for (int n = 0; n < SLOTS; n++)
                begin
                    if (!slot_used[idx])
                    begin
                        empty_at = idx;
                        break;
                    end
                    if (same_key(slot_tok[idx]))
                    begin
                        hit = idx;
                        break;
                    end
                    idx = (idx + 1) & (SLOTS - 1);
                end
                if (hit >= 0)
                begin
                    a.st = ST_FOUND;
                    a.id = TOKEN_ID_W'(slot_tok[hit]);
                end
                else if (!act)
                    a.st = ST_NOT_FOUND;
                else if (empty_at < 0 || tok_count >= TOK_CAP || 2 * tok_count >= SLOTS)
                    a.st = ST_FULL;
                else
                begin
                    for (int i = 0; i < kcnt; i++) tok_bytes[tok_count][i] = kbuf[i];
                    tok_len[tok_count] = kcnt;
                    slot_tok[empty_at] = tok_count;
                    slot_used[empty_at] = 1;
                    a.st = ST_INSERTED;
                    a.id = TOKEN_ID_W'(tok_count);
                    tok_count++;
                end
            end
            answers.push_back(a);
            clear_key();
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [TOKEN_ID_W-1:0] id);
            answer_t a;
            if (answers.size() == 0)
            begin
                $error("unexpected result status=%0d token_id=%0d", st, id);
                errors++;
                return;
            end
            a = answers.pop_front();
            checked++;
            if (a.st <= ST_TOO_LONG) seen[a.st]++;
            if (st !== a.st)
            begin
                $error("status: expected %0d, actual %0d", a.st, st);
                errors++;
            end
            if (id !== a.id)
            begin
                $error("token_id: expected %0d, actual %0d", a.id, id);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  action;
    logic [7:0]            key_byte;
    logic                  key_last;
    logic                  out_valid;
    logic                  out_ready;
    logic [STATUS_W-1:0]   status;
    logic [TOKEN_ID_W-1:0] token_id;

    table_scoreboard sb;
    int   send_pct;
    int   recv_pct;
    int   hold_request;
    int   hold_left;
    int   quiet_cycles;
    logic [7:0] kb [24];
    logic [7:0] pool_bytes [POOL_N][24];
    int   pool_len [POOL_N];

    token_hash_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .key_byte  (key_byte),
        .key_last  (key_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .token_id  (token_id)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        action = 0;
        key_byte = 0;
        key_last = 0;
        out_ready = 0;
        send_pct = 0;
        recv_pct = 0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        sb = new();
    end

    // receiver side, with its own hold-off counter
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, token_id);
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIM)
        begin
            $display("token_hash_table_test: done, errors");
            $finish;
        end
    end

    task automatic send_byte(logic act, logic [7:0] b, logic last);
        if (send_pct > 0 && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        key_byte <= b;
        key_last <= last;
        do @(posedge clk); while (!in_ready);
        sb.note_transfer(act, b, last);
    endtask

    // key bytes come from kb; only the action on the last byte counts
    task automatic send_key(logic act, int len);
        for (int i = 0; i < len; i++)
            send_byte((i == len - 1) ? act : logic'($urandom_range(1)), kb[i], i == len - 1);
    endtask

    task automatic random_keys(int n);
        int p;
        int len;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 60)
            begin
                p = $urandom_range(POOL_N - 1);
                len = pool_len[p];
                for (int i = 0; i < len; i++) kb[i] = pool_bytes[p][i];
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 17) : $urandom_range(8, 1);
                for (int i = 0; i < len; i++) kb[i] = 8'($urandom_range(255));
            end
            send_key(logic'($urandom_range(1)), len);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < POOL_N; p++)
        begin
            pool_len[p] = (p % 8 == 0) ? $urandom_range(24, 17) : $urandom_range(8, 1);
            for (int i = 0; i < 24; i++) pool_bytes[p][i] = 8'($urandom_range(255));
        end

        // directed
        kb[0] = 8'h00;
        send_key(1'b0, 1);
        send_key(1'b1, 1);
        send_key(1'b1, 1);
        send_key(1'b0, 1);
        kb[0] = 8'hFF;
        send_key(1'b1, 1);
        send_key(1'b0, 1);
        for (int i = 0; i < 24; i++) kb[i] = (i % 2) ? 8'hFF : 8'h00;
        send_key(1'b0, 16);
        send_key(1'b1, 16);
        send_key(1'b0, 16);
        send_key(1'b1, 15);
        send_key(1'b0, 17);
        send_key(1'b1, 17);
        send_key(1'b1, 24);
        send_key(1'b0, 15);

        send_pct = 0;  recv_pct = 0;  random_keys(12);
        send_pct = 84; recv_pct = 0;  random_keys(12);
        send_pct = 0;  recv_pct = 84; random_keys(12);
        send_pct = 23; recv_pct = 23; random_keys(12);
        send_pct = 0;  recv_pct = 0;
        hold_request = 400;
        random_keys(8);
        send_pct = 23; recv_pct = 84; random_keys(8);

        in_valid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d results: found %0d, not found %0d, inserted %0d, full %0d,",
                 sb.checked, sb.seen[ST_FOUND], sb.seen[ST_NOT_FOUND], sb.seen[ST_INSERTED],
                 sb.seen[ST_FULL]);
        $display("too long %0d; idle and stall phases plus a long output hold-off",
                 sb.seen[ST_TOO_LONG]);
        if (sb.errors == 0 && sb.answers.size() == 0)
            $display("token_hash_table_test: done, clean");
        else
            $display("token_hash_table_test: done, errors");
        $finish;
    end

endmodule
